// ===== rtl/local_call_switch_leg_fsm_unit_macros.svh =====
// assertion helpers used by local_call_switch_leg_fsm_unit.sv
`ifndef LOCAL_CALL_SWITCH_LEG_FSM_UNIT_MACROS_SVH
`define LOCAL_CALL_SWITCH_LEG_FSM_UNIT_MACROS_SVH

// same-cycle implication, checked on clk with reset masking
`define LCLSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset masking
`define LCLSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lclsf_pkg.sv =====
package lclsf_pkg;

  localparam int CODE_W = 8;
  localparam int CFG_IDX_W = 8;

  localparam logic [CODE_W-1:0] UNSET_CODE = 8'hFF;
  localparam logic [CODE_W-1:0] RELEASE_RESET = 8'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GCR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BOTH_WAY = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONNECT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELEASE = 8'd3;

  typedef enum logic [2:0] {
    ST_NONE             = 3'd0,
    ST_NOT_YET          = 3'd1,
    ST_NOT_POSSIBLE     = 3'd2,
    ST_NO_LONGER        = 3'd3,
    ST_UNSUPPORTED      = 3'd4,
    ST_SWITCHED         = 3'd5,
    ST_WAIT_BREAK       = 3'd6,
    ST_WAIT_OTHER_BREAK = 3'd7
  } leg_state_t;

  typedef enum logic [2:0] {
    OP_UPDATE        = 3'd0,
    OP_APPLY         = 3'd1,
    OP_CORRELATED    = 3'd2,
    OP_OTHER_ENABLED = 3'd3,
    OP_OTHER_BREAK   = 3'd4,
    OP_OTHER_DEAD    = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    NS_NOT_YET          = 3'd0,
    NS_NOT_POSSIBLE     = 3'd1,
    NS_NO_LONGER        = 3'd2,
    NS_NOT_SUPPORTED    = 3'd3,
    NS_LOCALLY_SWITCHED = 3'd4
  } notify_status_t;

  typedef enum logic [1:0] {
    PM_NONE          = 2'd0,
    PM_OTHER_ENABLED = 2'd1,
    PM_OTHER_BREAK   = 2'd2
  } peer_msg_t;

  typedef enum logic [1:0] {
    PC_NONE    = 2'd0,
    PC_ENABLE  = 2'd1,
    PC_RESTORE = 2'd2
  } path_cmd_t;

  typedef struct packed {
    logic              gcr_present;
    logic [CODE_W-1:0] both_way_code;
    logic [CODE_W-1:0] connect_code;
    logic [CODE_W-1:0] rel_code;
  } lcls_cfg_t;

  typedef struct packed {
    opcode_t           opcode;
    logic              cfg_given;
    logic [CODE_W-1:0] cfg_value;
    logic              csc_given;
    logic [CODE_W-1:0] csc_value;
    logic              correlation_found;
    logic [CODE_W-1:0] peer_config;
    logic [CODE_W-1:0] peer_control;
  } item_t;

  typedef struct packed {
    leg_state_t        state;
    logic [CODE_W-1:0] own_config;
    logic [CODE_W-1:0] own_control;
    logic              peer_linked;
  } leg_ctx_t;

  typedef struct packed {
    leg_state_t     next_state;
    logic           notify_valid;
    notify_status_t notify_status;
    logic           tell_correlated;
    peer_msg_t      peer_message;
    path_cmd_t      path_command;
    logic           cfg_rejected;
    logic           bad_event;
  } result_t;

endpackage

// ===== rtl/local_call_switch_leg_fsm_unit.sv =====
// an accepted event beat is held in the input register, then registered into the result stage
// throughput: one event per cycle while the result is not stalled by out_ready low
// reset: synchronous active-low rst_n empties both stages, sets the leg to no
// local switching with config and control codes unset and the partner unlinked,
// and loads the register defaults (release code 2, all others 0)
module local_call_switch_leg_fsm_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lclsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lclsf_pkg::CODE_W-1:0]    cfg_data,
  // event channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_opcode,
  input  logic                            in_cfg_given,
  input  logic [7:0]                      in_cfg_value,
  input  logic                            in_csc_given,
  input  logic [7:0]                      in_csc_value,
  input  logic                            in_correlation_found,
  input  logic [7:0]                      in_peer_config,
  input  logic [7:0]                      in_peer_control,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_next_state,
  output logic                            out_notify_valid,
  output logic [2:0]                      out_notify_status,
  output logic                            out_tell_correlated,
  output logic [1:0]                      out_peer_message,
  output logic [1:0]                      out_path_command,
  output logic                            out_cfg_rejected,
  output logic                            out_bad_event
);
  import lclsf_pkg::*;

`include "local_call_switch_leg_fsm_unit_macros.svh"

  // input stage
  logic      in_v_r;
  item_t     in_item_r;
  // result stage
  logic      out_v_r;
  result_t   out_res_r;
  // leg context
  leg_ctx_t  ctx_r;
  leg_ctx_t  ctx_nxt;
  result_t   res_nxt;
  lcls_cfg_t cfg;
  logic      fire;

  lclsf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lclsf_core u_core (
    .ctx     (ctx_r),
    .cfg     (cfg),
    .item    (in_item_r),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  // the held event is evaluated when the result register is free or draining
  assign fire     = in_v_r && (!out_v_r || out_ready);
  // the input register refills in the same cycle it hands its beat on
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r.opcode            <= opcode_t'(in_opcode);
      in_item_r.cfg_given         <= in_cfg_given;
      in_item_r.cfg_value         <= in_cfg_value;
      in_item_r.csc_given         <= in_csc_given;
      in_item_r.csc_value         <= in_csc_value;
      in_item_r.correlation_found <= in_correlation_found;
      in_item_r.peer_config       <= in_peer_config;
      in_item_r.peer_control      <= in_peer_control;
    end
  end

  // leg context moves only when an event is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state       <= ST_NONE;
      ctx_r.own_config  <= UNSET_CODE;
      ctx_r.own_control <= UNSET_CODE;
      ctx_r.peer_linked <= 1'b0;
    end else if (fire) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_next_state      = out_res_r.next_state;
  assign out_notify_valid    = out_res_r.notify_valid;
  assign out_notify_status   = out_res_r.notify_status;
  assign out_tell_correlated = out_res_r.tell_correlated;
  assign out_peer_message    = out_res_r.peer_message;
  assign out_path_command    = out_res_r.path_command;
  assign out_cfg_rejected    = out_res_r.cfg_rejected;
  assign out_bad_event       = out_res_r.bad_event;

  // a flagged event leaves the leg context untouched
  `LCLSF_ASSERT_NXT(a_bad_keeps_ctx, fire && res_nxt.bad_event, ctx_r == $past(ctx_r), "bad event changed the leg context")
  // a flagged event carries no action
  `LCLSF_ASSERT_IMP(a_bad_no_action, out_v_r && out_res_r.bad_event, (out_res_r.path_command == PC_NONE) && (out_res_r.peer_message == PM_NONE) && !out_res_r.notify_valid && !out_res_r.tell_correlated && !out_res_r.cfg_rejected, "bad event with actions")
  // a rejected config always lands in the unsupported state
  `LCLSF_ASSERT_IMP(a_reject_state, out_v_r && out_res_r.cfg_rejected, out_res_r.next_state == ST_UNSUPPORTED, "rejected config outside unsupported state")
  // a stalled result blocks evaluation of the held event
  `LCLSF_ASSERT_IMP(a_stall_holds, in_v_r && out_v_r && !out_ready, !fire && !in_ready, "event evaluated into a stalled result")

endmodule

// ===== rtl/lclsf_cfg.sv =====
module lclsf_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lclsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lclsf_pkg::CODE_W-1:0]     cfg_data,
  output lclsf_pkg::lcls_cfg_t             cfg
);
  import lclsf_pkg::*;

  lcls_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gcr_present   <= 1'b0;
      cfg_r.both_way_code <= '0;
      cfg_r.connect_code  <= '0;
      cfg_r.rel_code      <= RELEASE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_GCR:      cfg_r.gcr_present   <= cfg_data[0];
        CFG_IDX_BOTH_WAY: cfg_r.both_way_code <= cfg_data;
        CFG_IDX_CONNECT:  cfg_r.connect_code  <= cfg_data;
        CFG_IDX_RELEASE:  cfg_r.rel_code      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lclsf_core.sv =====
module lclsf_core (
  input  lclsf_pkg::leg_ctx_t  ctx,
  input  lclsf_pkg::lcls_cfg_t cfg,
  input  lclsf_pkg::item_t     item,
  output lclsf_pkg::leg_ctx_t  ctx_nxt,
  output lclsf_pkg::result_t   res
);
  import lclsf_pkg::*;

  logic [CODE_W-1:0] upd_cfg;
  logic [CODE_W-1:0] upd_ctl;
  logic              peer_ok;
  logic              own_ok;
  logic              en_upd;
  logic              en_cur;
  logic              en_app;
  logic              cfg_bad;
  logic              empty_upd;
  logic              blocked;
  logic              apply_skip;
  logic              bad;
  leg_state_t        st;
  leg_state_t        ns;

  assign st       = ctx.state;
  assign upd_cfg  = item.cfg_given ? item.cfg_value : ctx.own_config;
  assign upd_ctl  = item.csc_given ? item.csc_value : ctx.own_control;
  assign peer_ok  = (item.peer_config == cfg.both_way_code) &&
                    (item.peer_control == cfg.connect_code);
  assign own_ok   = (ctx.own_config == cfg.both_way_code) &&
                    (ctx.own_control == cfg.connect_code);
  // the update path checks the codes it is about to write
  assign en_upd   = ctx.peer_linked && peer_ok && (upd_cfg == cfg.both_way_code) &&
                    (upd_ctl == cfg.connect_code);
  assign en_cur   = ctx.peer_linked && own_ok && peer_ok;
  // apply links to the found partner before checking
  assign en_app   = item.correlation_found && own_ok && peer_ok;
  assign cfg_bad  = item.cfg_given && (item.cfg_value != cfg.both_way_code);
  assign empty_upd = (item.opcode == OP_UPDATE) && !item.cfg_given && !item.csc_given;
  assign blocked  = !empty_upd && (st == ST_NONE) && !cfg.gcr_present;
  assign apply_skip = (st == ST_NONE) && (ctx.own_config == UNSET_CODE);

  // next state and stored context
  always_comb begin
    ctx_nxt = ctx;
    bad = 1'b0;
    if (empty_upd) begin
    end else if (blocked) begin
      bad = 1'b1;
    end else begin
      case (item.opcode)
        OP_UPDATE: begin
          if (cfg_bad) begin
            ctx_nxt.state = ST_UNSUPPORTED;
          end else begin
            ctx_nxt.own_config  = upd_cfg;
            ctx_nxt.own_control = upd_ctl;
            if (st == ST_NO_LONGER && en_upd) ctx_nxt.state = ST_SWITCHED;
          end
        end
        OP_APPLY: begin
          case (st)
            ST_NONE, ST_NOT_POSSIBLE, ST_UNSUPPORTED: begin
              if (!apply_skip) begin
                ctx_nxt.peer_linked = item.correlation_found;
                if (!item.correlation_found) begin
                  if (st != ST_NOT_POSSIBLE) ctx_nxt.state = ST_NOT_POSSIBLE;
                end else if (st != ST_UNSUPPORTED ||
                             ctx.own_config == cfg.both_way_code) begin
                  ctx_nxt.state = en_app ? ST_SWITCHED : ST_NOT_YET;
                end
              end
            end
            ST_NOT_YET: if (en_cur) ctx_nxt.state = ST_SWITCHED;
            ST_SWITCHED: begin
              if (ctx.own_control == cfg.rel_code) ctx_nxt.state = ST_WAIT_OTHER_BREAK;
            end
            ST_WAIT_BREAK: begin
              if (ctx.own_control == cfg.rel_code) ctx_nxt.state = ST_NO_LONGER;
            end
            default: bad = 1'b1;
          endcase
        end
        OP_CORRELATED: begin
          case (st)
            ST_NOT_YET, ST_NO_LONGER, ST_UNSUPPORTED: ctx_nxt.peer_linked = 1'b1;
            ST_NOT_POSSIBLE: begin
              ctx_nxt.peer_linked = 1'b1;
              ctx_nxt.state = ST_NOT_YET;
            end
            default: bad = 1'b1;
          endcase
        end
        OP_OTHER_ENABLED: begin
          case (st)
            ST_NOT_YET, ST_NO_LONGER: if (en_cur) ctx_nxt.state = ST_SWITCHED;
            default: bad = 1'b1;
          endcase
        end
        OP_OTHER_BREAK: begin
          case (st)
            ST_SWITCHED:         ctx_nxt.state = ST_WAIT_BREAK;
            ST_WAIT_BREAK:       ;
            ST_WAIT_OTHER_BREAK: ctx_nxt.state = ST_NO_LONGER;
            default:             bad = 1'b1;
          endcase
        end
        OP_OTHER_DEAD: begin
          case (st)
            ST_NOT_YET, ST_NO_LONGER, ST_SWITCHED: begin
              ctx_nxt.peer_linked = 1'b0;
              ctx_nxt.state = ST_NOT_POSSIBLE;
            end
            ST_UNSUPPORTED, ST_WAIT_BREAK: ctx_nxt.peer_linked = 1'b0;
            ST_WAIT_OTHER_BREAK: begin
              ctx_nxt.peer_linked = 1'b0;
              ctx_nxt.state = ST_NO_LONGER;
            end
            default: bad = 1'b1;
          endcase
        end
        default: bad = 1'b1;
      endcase
    end
  end

  assign ns = ctx_nxt.state;

  // result fields
  always_comb begin
    res = '0;
    res.next_state = ns;
    res.bad_event  = bad;
    if (!empty_upd && !blocked) begin
      case (item.opcode)
        OP_UPDATE: begin
          if (cfg_bad) begin
            res.cfg_rejected = 1'b1;
            if (st == ST_SWITCHED || st == ST_WAIT_BREAK || st == ST_WAIT_OTHER_BREAK)
              res.path_command = PC_RESTORE;
          end else if (st == ST_NO_LONGER && en_upd) begin
            res.path_command = PC_ENABLE;
            res.peer_message = PM_OTHER_ENABLED;
          end
        end
        OP_APPLY: begin
          case (st)
            ST_NONE, ST_NOT_POSSIBLE: begin
              if (!apply_skip) begin
                res.tell_correlated = item.correlation_found;
                if (en_app) begin
                  res.path_command = PC_ENABLE;
                  res.peer_message = PM_OTHER_ENABLED;
                end
              end
            end
            ST_UNSUPPORTED: begin
              res.tell_correlated = item.correlation_found;
              if (en_app) res.path_command = PC_ENABLE;
            end
            ST_NOT_YET: begin
              if (en_cur) begin
                res.path_command = PC_ENABLE;
                res.peer_message = PM_OTHER_ENABLED;
              end
            end
            ST_SWITCHED: begin
              if (ctx.own_control == cfg.rel_code) res.peer_message = PM_OTHER_BREAK;
            end
            ST_WAIT_BREAK: begin
              if (ctx.own_control == cfg.rel_code) begin
                res.path_command = PC_RESTORE;
                res.peer_message = PM_OTHER_BREAK;
              end
            end
            default: ;
          endcase
        end
        OP_CORRELATED: begin
          if (st == ST_NOT_POSSIBLE) res.notify_valid = 1'b1;
        end
        OP_OTHER_ENABLED: begin
          if (st == ST_NOT_YET || st == ST_NO_LONGER) begin
            if (en_cur) begin
              res.path_command = PC_ENABLE;
              res.notify_valid = 1'b1;
            end else begin
              res.peer_message = PM_OTHER_BREAK;
            end
          end
        end
        OP_OTHER_BREAK: begin
          if (st == ST_WAIT_OTHER_BREAK) begin
            res.path_command = PC_RESTORE;
            res.notify_valid = 1'b1;
          end
        end
        OP_OTHER_DEAD: begin
          case (st)
            ST_NOT_YET, ST_NO_LONGER, ST_SWITCHED: res.notify_valid = 1'b1;
            ST_WAIT_OTHER_BREAK: begin
              res.path_command = PC_RESTORE;
              res.notify_valid = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (res.notify_valid) begin
      case (ns)
        ST_NOT_YET:      res.notify_status = NS_NOT_YET;
        ST_NOT_POSSIBLE: res.notify_status = NS_NOT_POSSIBLE;
        ST_NO_LONGER:    res.notify_status = NS_NO_LONGER;
        ST_UNSUPPORTED:  res.notify_status = NS_NOT_SUPPORTED;
        default:         res.notify_status = NS_LOCALLY_SWITCHED;
      endcase
    end
  end

endmodule
